[hdl/cdr_pkg.sv]
// shared types and constants of the command record deframer
// no dependencies; cdr_front, cdr_queue, cdr_back and the core refer to this package by scoped names
package cdr_pkg;

    localparam logic [7:0] OPC_ATTACK = 8'h80;
    localparam logic [7:0] OPC_RESET  = 8'h81;
    localparam logic [7:0] OPC_CLAMP  = 8'h82;

    // index of the final payload byte of each record
    localparam logic [3:0] ATTACK_LAST = 4'd12;
    localparam logic [3:0] CLAMP_LAST  = 4'd11;

    // payload bytes kept before the final one arrives
    localparam int HELD_DEPTH = 12;

    typedef enum logic [1:0] {
        REC_ATTACK     = 2'd0,
        REC_CLAMP      = 2'd1,
        REC_ZONE_RESET = 2'd2
    } rec_kind_t;

    typedef enum logic [1:0] {
        EV_DATA = 2'd0,
        EV_LAST = 2'd1,
        EV_ZONE = 2'd2
    } ev_op_t;

    typedef struct packed {
        ev_op_t     op;
        logic       attack;
        logic [3:0] index;
        logic [7:0] data;
    } cdr_event_t;

endpackage

[hdl/cdr_byte_if.sv]
// inbound byte channel of the deframer: valid/ready handshake with byte and restart flag
// depends on nothing
interface cdr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       restart;

    modport source (output valid, output rx_byte, output restart, input ready);
    modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

[hdl/cdr_record_if.sv]
// outbound record channel of the deframer: valid/ready handshake with decoded fields
// depends on nothing
interface cdr_record_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [31:0] mob_id;
    logic [31:0] avatar_id;
    logic [31:0] amount;
    logic [7:0]  element;

    modport source (output valid, output record_kind, output mob_id, output avatar_id,
                    output amount, output element, input ready);
    modport sink   (input valid, input record_kind, input mob_id, input avatar_id,
                    input amount, input element, output ready);
endinterface

[hdl/cdr_front.sv]
// front end: accepts bytes, tracks the open record and turns payload bytes and zone resets into events
// depends on cdr_pkg and cdr_byte_if
module cdr_front
(
    input  logic               clk,
    input  logic               rst_n,
    cdr_byte_if.sink           rx,
    input  logic               queue_ready,
    output logic               push,
    output cdr_pkg::cdr_event_t push_event
);

    typedef enum logic [1:0] {
        IDLE,
        OPEN_ATTACK,
        OPEN_CLAMP
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [3:0] count_reg;
    logic [3:0] count_next;
    state_t     cur_state;
    logic [3:0] cur_count;
    logic [3:0] last_index;
    logic       accept;

    assign rx.ready = queue_ready;
    assign accept   = rx.valid & queue_ready;

    // restart drops the open record before the byte is looked at
    assign cur_state  = rx.restart ? IDLE : state_reg;
    assign cur_count  = rx.restart ? 4'd0 : count_reg;
    assign last_index = (cur_state == OPEN_ATTACK) ? cdr_pkg::ATTACK_LAST : cdr_pkg::CLAMP_LAST;

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        push              = 1'b0;
        push_event.op     = cdr_pkg::EV_DATA;
        push_event.attack = (cur_state == OPEN_ATTACK);
        push_event.index  = cur_count;
        push_event.data   = rx.rx_byte;
        if (accept)
        begin
            case (cur_state)
                OPEN_ATTACK, OPEN_CLAMP:
                begin
                    push = 1'b1;
                    if (cur_count == last_index)
                    begin
                        push_event.op = cdr_pkg::EV_LAST;
                        state_next    = IDLE;
                        count_next    = 4'd0;
                    end
                    else
                    begin
                        state_next = cur_state;
                        count_next = cur_count + 4'd1;
                    end
                end
                default:
                begin
                    count_next = 4'd0;
                    state_next = IDLE;
                    case (rx.rx_byte)
                        cdr_pkg::OPC_ATTACK: state_next = OPEN_ATTACK;
                        cdr_pkg::OPC_CLAMP:  state_next = OPEN_CLAMP;
                        cdr_pkg::OPC_RESET:
                        begin
                            push          = 1'b1;
                            push_event.op = cdr_pkg::EV_ZONE;
                        end
                        default:             state_next = IDLE;
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            count_reg <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

[hdl/cdr_queue.sv]
// short event queue between front and back end
// depends on cdr_pkg
module cdr_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cdr_pkg::cdr_event_t push_data,
    output logic                push_ready,
    input  logic                pop,
    output logic                pop_valid,
    output cdr_pkg::cdr_event_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

    cdr_pkg::cdr_event_t slot_reg [0:DEPTH-1];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != CNT_DEPTH);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push & push_ready;
    assign do_pop     = pop & pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/cdr_back.sv]
// back end: stores payload bytes and assembles each finished record into the output register
// depends on cdr_pkg and cdr_record_if
module cdr_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ev_valid,
    input  cdr_pkg::cdr_event_t ev,
    output logic                pop,
    cdr_record_if.source        rec
);

    logic [7:0]  held_reg [0:cdr_pkg::HELD_DEPTH-1];
    logic [7:0]  bytes    [0:cdr_pkg::HELD_DEPTH-1];
    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [31:0] mob_reg;
    logic [31:0] avatar_reg;
    logic [31:0] amount_reg;
    logic [7:0]  element_reg;
    logic        is_result;
    logic        slot_free;
    logic        take_result;

    assign is_result   = (ev.op != cdr_pkg::EV_DATA);
    assign slot_free   = !valid_reg || rec.ready;
    assign pop         = ev_valid && (!is_result || slot_free);
    assign take_result = pop && is_result;

    // final byte of a clamp record lands in the top byte of amount
    always_comb
    begin
        for (int i = 0; i < cdr_pkg::HELD_DEPTH; i++)
        begin
            bytes[i] = (ev.index == 4'(i)) ? ev.data : held_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && ev.op == cdr_pkg::EV_DATA)
        begin
            held_reg[ev.index] <= ev.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_result)
        begin
            if (ev.op == cdr_pkg::EV_ZONE)
            begin
                kind_reg    <= cdr_pkg::REC_ZONE_RESET;
                mob_reg     <= '0;
                avatar_reg  <= '0;
                amount_reg  <= '0;
                element_reg <= '0;
            end
            else
            begin
                kind_reg    <= ev.attack ? cdr_pkg::REC_ATTACK : cdr_pkg::REC_CLAMP;
                mob_reg     <= {bytes[3], bytes[2], bytes[1], bytes[0]};
                avatar_reg  <= {bytes[7], bytes[6], bytes[5], bytes[4]};
                amount_reg  <= {bytes[11], bytes[10], bytes[9], bytes[8]};
                element_reg <= ev.attack ? ev.data : 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take_result)
        begin
            valid_reg <= 1'b1;
        end
        else if (rec.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign rec.valid       = valid_reg;
    assign rec.record_kind = kind_reg;
    assign rec.mob_id      = mob_reg;
    assign rec.avatar_id   = avatar_reg;
    assign rec.amount      = amount_reg;
    assign rec.element     = element_reg;

endmodule

[hdl/command_record_deframer_core.sv]
// command record deframer top: front end, event queue, back end
// a record's result word is registered once its last event has passed the queue and the output register is free
// throughput: one byte per cycle while the queue has room; the front end classifier is combinational
// a waiting result word holds back the next result event; the queue fills up, then input stalls
// reset: rst_n clears the open record, the queue and the output valid; no clearing pass
module command_record_deframer_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    cdr_byte_if.sink     rx,
    cdr_record_if.source rec
);

    logic                push;
    logic                push_ready;
    cdr_pkg::cdr_event_t push_event;
    logic                pop;
    logic                pop_valid;
    cdr_pkg::cdr_event_t pop_event;

    cdr_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .queue_ready (push_ready),
        .push        (push),
        .push_event  (push_event)
    );

    cdr_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_event),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_event)
    );

    cdr_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_valid (pop_valid),
        .ev       (pop_event),
        .pop      (pop),
        .rec      (rec)
    );

endmodule

[tb/sv/testbench.sv]
// testbench for command_record_deframer_core: byte streams in, decoded records checked out
// depends on cdr_pkg, cdr_byte_if, cdr_record_if and the core in hdl
// a local deframer model predicts every record; idling and stalls on both channels
module testbench;

    import cdr_pkg::*;

    localparam logic [3:0] ATTACK_BODY = 4'd13;
    localparam logic [3:0] CLAMP_BODY  = 4'd12;
    localparam int PHASE_ITEMS = 476;

    typedef enum logic [1:0] {
        OPEN_NONE   = 2'd0,
        OPEN_ATTACK = 2'd1,
        OPEN_CLAMP  = 2'd2
    } open_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } rx_word_t;

    typedef struct packed {
        rec_kind_t   kind;
        logic [31:0] mob_id;
        logic [31:0] avatar_id;
        logic [31:0] amount;
        logic [7:0]  element;
    } record_t;

    logic clk;
    logic rst_n;

    cdr_byte_if   rx_chan ();
    cdr_record_if rec_chan ();

    command_record_deframer_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_chan),
        .rec   (rec_chan)
    );

    rx_word_t   pending_bytes[$];
    record_t    expected_records[$];
    open_kind_t open_kind;
    logic [3:0] open_count;
    logic [7:0] open_body [0:12];
    int         send_idle_pct;
    int         recv_idle_pct;
    int         mismatch_count;
    int         items_made;
    rx_word_t   next_word;
    record_t    predicted;
    record_t    want;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit deframe_byte(input logic [7:0] b, input logic rs,
                                        output record_t r);
        logic [3:0] need;
        r = '0;
        if (rs)
        begin
            open_kind  = OPEN_NONE;
            open_count = '0;
        end
        if (open_kind == OPEN_NONE)
        begin
            open_count = '0;
            if (b == OPC_ATTACK)
                open_kind = OPEN_ATTACK;
            else if (b == OPC_CLAMP)
                open_kind = OPEN_CLAMP;
            else if (b == OPC_RESET)
            begin
                r.kind = REC_ZONE_RESET;
                return 1'b1;
            end
            return 1'b0;
        end
        need = (open_kind == OPEN_ATTACK) ? ATTACK_BODY : CLAMP_BODY;
        open_body[open_count] = b;
        open_count = open_count + 4'd1;
        if (open_count < need)
            return 1'b0;
        r.kind      = (open_kind == OPEN_ATTACK) ? REC_ATTACK : REC_CLAMP;
        r.mob_id    = {open_body[3], open_body[2], open_body[1], open_body[0]};
        r.avatar_id = {open_body[7], open_body[6], open_body[5], open_body[4]};
        r.amount    = {open_body[11], open_body[10], open_body[9], open_body[8]};
        r.element   = (open_kind == OPEN_ATTACK) ? open_body[12] : 8'h00;
        open_kind   = OPEN_NONE;
        open_count  = '0;
        return 1'b1;
    endfunction

    // byte driver and predictor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_chan.valid   <= 1'b0;
            rx_chan.rx_byte <= 8'h00;
            rx_chan.restart <= 1'b0;
        end
        else
        begin
            if (rx_chan.valid && rx_chan.ready)
            begin
                if (deframe_byte(rx_chan.rx_byte, rx_chan.restart, predicted))
                    expected_records.push_back(predicted);
            end
            if (!rx_chan.valid || rx_chan.ready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_word = pending_bytes.pop_front();
                    rx_chan.valid   <= 1'b1;
                    rx_chan.rx_byte <= next_word.data;
                    rx_chan.restart <= next_word.restart;
                end
                else
                    rx_chan.valid <= 1'b0;
            end
        end
    end

    // record monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            rec_chan.ready <= 1'b0;
        else
        begin
            if (rec_chan.valid && rec_chan.ready)
            begin
                if (expected_records.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected record: kind %0d mob %h avatar %h amount %h elem %h",
                                 rec_chan.record_kind, rec_chan.mob_id, rec_chan.avatar_id,
                                 rec_chan.amount, rec_chan.element);
                end
                else
                begin
                    want = expected_records.pop_front();
                    if (rec_chan.record_kind !== want.kind || rec_chan.mob_id !== want.mob_id
                        || rec_chan.avatar_id !== want.avatar_id
                        || rec_chan.amount !== want.amount || rec_chan.element !== want.element)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("record mismatch: expected kind %0d mob %h avatar %h amount %h elem %h",
                                     want.kind, want.mob_id, want.avatar_id, want.amount,
                                     want.element);
                            $display("                 actual   kind %0d mob %h avatar %h amount %h elem %h",
                                     rec_chan.record_kind, rec_chan.mob_id, rec_chan.avatar_id,
                                     rec_chan.amount, rec_chan.element);
                        end
                    end
                end
            end
            rec_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic rs, input bit counted);
        rx_word_t w;
        w.data    = b;
        w.restart = rs;
        pending_bytes.push_back(w);
        if (counted)
            items_made++;
    endtask

    function automatic logic [7:0] body_byte();
        int pick;
        pick = $urandom_range(39);
        case (pick)
            0: return 8'h00;
            1: return 8'hFF;
            2: return OPC_ATTACK;
            3: return OPC_RESET;
            4: return OPC_CLAMP;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == OPC_ATTACK || b == OPC_RESET || b == OPC_CLAMP)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    // mostly well-formed records, some noise and records cut short by restart
    task automatic fill_random(input int n);
        int         stop_at;
        int         pick;
        int         len;
        logic       rs_first;
        logic [7:0] opc;
        stop_at = items_made + n;
        while (items_made < stop_at)
        begin
            pick     = $urandom_range(99);
            rs_first = ($urandom_range(7) == 0);
            opc      = ($urandom_range(1) == 0) ? OPC_ATTACK : OPC_CLAMP;
            if (pick < 76)
            begin
                queue_byte(opc, rs_first, 1'b1);
                len = (opc == OPC_ATTACK) ? ATTACK_BODY : CLAMP_BODY;
                repeat (len)
                    queue_byte(body_byte(), 1'b0, 1'b1);
            end
            else if (pick < 86)
                queue_byte(OPC_RESET, rs_first, 1'b1);
            else if (pick < 93)
                queue_byte(noise_byte(), 1'($urandom_range(1)), 1'b0);
            else
            begin
                queue_byte(opc, rs_first, 1'b1);
                len = $urandom_range((opc == OPC_ATTACK) ? 12 : 11);
                repeat (len)
                    queue_byte(body_byte(), 1'b0, 1'b1);
                queue_byte(8'($urandom_range(255)), 1'b1, 1'b1);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || rx_chan.valid || expected_records.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] attack_body [13];
        attack_body = '{8'h81, 8'h82, 8'h80, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        rst_n            = 1'b0;
        rx_chan.valid    = 1'b0;
        rx_chan.rx_byte  = 8'h00;
        rx_chan.restart  = 1'b0;
        rec_chan.ready   = 1'b0;
        open_kind        = OPEN_NONE;
        open_count       = '0;
        mismatch_count   = 0;
        items_made       = 0;
        send_idle_pct    = 9;
        recv_idle_pct    = 63;
        for (int i = 0; i < 13; i++)
            open_body[i] = 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // skipped bytes, zone reset under restart, opcodes as payload
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'h7F, 1'b0, 1'b1);
        queue_byte(8'h83, 1'b1, 1'b1);
        queue_byte(OPC_RESET, 1'b1, 1'b1);
        queue_byte(OPC_ATTACK, 1'b0, 1'b1);
        for (int i = 0; i < 13; i++)
            queue_byte(attack_body[i], 1'b0, 1'b1);
        // partial clamp dropped by restart on a zone reset
        queue_byte(OPC_CLAMP, 1'b0, 1'b1);
        queue_byte(OPC_ATTACK, 1'b0, 1'b1);
        queue_byte(OPC_RESET, 1'b0, 1'b1);
        queue_byte(OPC_RESET, 1'b1, 1'b1);
        fill_random(PHASE_ITEMS);

        // sender holds off until every record is out
        wait_drained();
        send_idle_pct = 63;
        recv_idle_pct = 9;
        fill_random(PHASE_ITEMS);

        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fill_random(PHASE_ITEMS);

        wait_drained();
        repeat (8) @(negedge clk);
        if (expected_records.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/cdr_pkg.sv
hdl/cdr_byte_if.sv
hdl/cdr_record_if.sv
hdl/cdr_front.sv
hdl/cdr_queue.sv
hdl/cdr_back.sv
hdl/command_record_deframer_core.sv
tb/sv/testbench.sv
